// ----- sv/i2a_pkg.sv -----
// ----------------------------------------------------------------------------
// i2a_pkg: integer to ASCII formatter package
// Transfer types, character constants and the digit to character mapping.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int unsigned MaxChars = 64;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharAlpha = 8'h41;
  localparam logic [7:0] CharMinus = 8'h2D;

  localparam logic [2:0] BaseDec   = 3'd3;
  localparam logic [2:0] BaseMax   = 3'd5;

  typedef struct packed {
    logic [63:0]       value;
    logic              is_signed;
    logic [2:0]        base_code;
    logic signed [7:0] pad_width;
    logic [7:0]        pad_char;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
    logic [6:0] length;
  } out_t;

  function automatic logic [7:0] digit_char(input logic [4:0] d);
    logic [7:0] r;
    if (d < 5'd10) begin
      r = CharZero + {3'b000, d};
    end else begin
      r = CharAlpha + {3'b000, d} - 8'd10;
    end
    return r;
  endfunction

endpackage

// ----- sv/integer_to_ascii_formatter.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a 64-bit number as ASCII text, one character per output transfer,
// sign first, then fill, then digits most significant first.
// ----------------------------------------------------------------------------
// Sequence: decimal items first pass through bit-serial BCD conversion, then
// every item skips leading zero digits (up to 63), ends the scan and passes a
// setup step before the first character is registered.
// Throughput: one character per cycle while the output is not stalled; an
// item holds off the input until its last character has been registered.
// Reset clears the sequencer and output valid; data registers are not reset.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  i2a_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output i2a_pkg::out_t out_data_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StConv  = 3'd1;
  localparam logic [2:0] StCount = 3'd2;
  localparam logic [2:0] StSetup = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic [5:0]  cnt_q, cnt_d;

  logic [79:0] dig_q, dig_d;
  logic [63:0] mag_q, mag_d;
  logic [2:0]  w_q, w_d;
  logic [6:0]  rem_q, rem_d;
  logic [6:0]  full_q, full_d;
  logic        neg_q, neg_d;
  logic        dec_q, dec_d;
  logic [7:0]  pad_q, pad_d;
  logic [7:0]  padc_q, padc_d;
  logic [6:0]  fill_q, fill_d;
  logic [6:0]  total_q, total_d;
  logic [6:0]  k_q, k_d;
  i2a_pkg::out_t out_q, out_d;

  logic        accept;
  logic        emit;
  logic [2:0]  code;
  logic [2:0]  shift;
  logic [4:0]  top;
  logic [79:0] adj;
  logic [6:0]  pad_eff;
  logic [6:0]  need;
  logic [63:0] v;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != StIdle);
  assign emit        = (state_q == StEmit) && (!out_valid_q || !out_stall_i);
  assign top         = dig_q[79:75] >> (3'd5 - w_q);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    for (int i = 0; i < 20; i++) begin
      adj[i*4 +: 4] = (dig_q[i*4 +: 4] >= 4'd5) ? dig_q[i*4 +: 4] + 4'd3 : dig_q[i*4 +: 4];
    end
  end

  always_comb begin
    if (pad_q[7]) begin
      pad_eff = dec_q ? 7'd0 : full_q;
    end else if (pad_q > 8'(i2a_pkg::MaxChars)) begin
      pad_eff = 7'(i2a_pkg::MaxChars);
    end else begin
      pad_eff = pad_q[6:0];
    end
    need = rem_q + {6'd0, neg_q};
  end

  always_comb begin
    code  = (in_data_i.base_code > i2a_pkg::BaseMax) ? i2a_pkg::BaseMax : in_data_i.base_code;
    shift = (code < i2a_pkg::BaseDec) ? code + 3'd1 : code;
    v     = in_data_i.value;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cnt_d       = cnt_q;
    dig_d       = dig_q;
    mag_d       = mag_q;
    w_d         = w_q;
    rem_d       = rem_q;
    full_d      = full_q;
    neg_d       = neg_q;
    dec_d       = dec_q;
    pad_d       = pad_q;
    padc_d      = padc_q;
    fill_d      = fill_q;
    total_d     = total_q;
    k_d         = k_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          pad_d  = in_data_i.pad_width;
          padc_d = in_data_i.pad_char;
          neg_d  = in_data_i.is_signed && v[63];
          if (in_data_i.is_signed || code == i2a_pkg::BaseDec) begin
            dec_d   = 1'b1;
            mag_d   = (in_data_i.is_signed && v[63]) ? ~v + 64'd1 : v;
            dig_d   = '0;
            w_d     = 3'd4;
            rem_d   = 7'd20;
            full_d  = 7'd20;
            cnt_d   = 6'd63;
            state_d = StConv;
          end else begin
            dec_d = 1'b0;
            w_d   = shift;
            case (shift)
              3'd3: begin
                dig_d  = {2'b00, v, 14'd0};
                full_d = 7'd22;
              end
              3'd5: begin
                dig_d  = {1'b0, v, 15'd0};
                full_d = 7'd13;
              end
              3'd1: begin
                dig_d  = {v, 16'd0};
                full_d = 7'd64;
              end
              3'd2: begin
                dig_d  = {v, 16'd0};
                full_d = 7'd32;
              end
              default: begin
                dig_d  = {v, 16'd0};
                full_d = 7'd16;
              end
            endcase
            rem_d   = full_d;
            state_d = StCount;
          end
        end
      end
      StConv: begin
        dig_d = {adj[78:0], mag_q[63]};
        mag_d = {mag_q[62:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          state_d = StCount;
        end
      end
      StCount: begin
        if (rem_q > 7'd1 && top == 5'd0) begin
          dig_d = dig_q << w_q;
          rem_d = rem_q - 7'd1;
        end else begin
          state_d = StSetup;
        end
      end
      StSetup: begin
        fill_d  = (pad_eff > need) ? pad_eff - need : 7'd0;
        total_d = need + fill_d;
        k_d     = '0;
        state_d = StEmit;
      end
      StEmit: begin
        if (emit) begin
          out_valid_d   = 1'b1;
          out_d.length  = total_q;
          out_d.last    = (k_q == total_q - 7'd1);
          k_d           = k_q + 7'd1;
          if (neg_q) begin
            out_d.char_out = i2a_pkg::CharMinus;
            neg_d          = 1'b0;
          end else if (fill_q != 7'd0) begin
            out_d.char_out = padc_q;
            fill_d         = fill_q - 7'd1;
          end else begin
            out_d.char_out = i2a_pkg::digit_char(top);
            dig_d          = dig_q << w_q;
            rem_d          = rem_q - 7'd1;
          end
          if (k_q == total_q - 7'd1) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    dig_q   <= dig_d;
    mag_q   <= mag_d;
    w_q     <= w_d;
    rem_q   <= rem_d;
    full_q  <= full_d;
    neg_q   <= neg_d;
    dec_q   <= dec_d;
    pad_q   <= pad_d;
    padc_q  <= padc_d;
    fill_q  <= fill_d;
    total_q <= total_d;
    k_q     <= k_d;
    out_q   <= out_d;
  end

endmodule

// ----- sv/i2a_checker.sv -----
// ----------------------------------------------------------------------------
// i2a_checker: port-level checks for the integer to ASCII formatter
// Watches the transfer handshakes and the per-number output framing.
// ----------------------------------------------------------------------------
module i2a_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input i2a_pkg::out_t out_data_o
);

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  // an accepted number blocks further input until formatted
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input accepted twice in a row");

  // characters of one number follow back to back with a constant length
  a_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !out_data_o.last |=>
      out_valid_o && out_data_o.length == $past(out_data_o.length))
    else $error("gap or length change inside a number");

  // no input is taken while a number is still mid-text
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && !out_data_o.last |-> in_stall_o)
    else $error("input accepted mid-number");

  a_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.length != 7'd0 && out_data_o.length <= 7'd64)
    else $error("length out of range");

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (.*);

// ----- tb/sv/integer_to_ascii_formatter_tb.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Self-checking bench for the integer to ASCII formatter. A directed table of
// numbers is followed by random ones, with random gaps on both channels, a
// long output hold-off and a mid-run drain. Every character is checked
// against a behavioural formatter or a literal text.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;

  localparam int          ClkPeriod   = 4;
  localparam int          ResetCycles = 12;
  localparam int          NumRandom   = 430;
  localparam int unsigned HoldAfter   = 1200;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned IdleLimit   = 3000;
  localparam int          DrainCycles = 300;
  localparam string       DigitSet    = "0123456789ABCDEFGHIJKLMNOPQRSTUV";

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i;
  logic           in_stall_o;
  i2a_pkg::in_t   in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  i2a_pkg::out_t  out_data_o;

  i2a_pkg::out_t pending_chars[$];
  i2a_pkg::in_t  table_items[$];
  string         table_texts[$];
  int unsigned   mismatches = 0;
  int unsigned   chars_taken = 0;
  int unsigned   idle_cycles = 0;
  bit            no_gaps = 1'b0;

  integer_to_ascii_formatter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic void format_text(input i2a_pkg::in_t item);
    logic [63:0] mag;
    logic [2:0]  code;
    logic        neg;
    logic        dec;
    logic [4:0]  digs [64];
    logic [7:0]  c;
    int          shift;
    int          pad;
    int          nd;
    int          fill;
    int          total;
    int          pos;
    mag   = item.value;
    code  = (item.base_code > i2a_pkg::BaseMax) ? i2a_pkg::BaseMax : item.base_code;
    neg   = 1'b0;
    shift = 0;
    if (item.is_signed) begin
      dec = 1'b1;
      if (mag[63]) begin
        neg = 1'b1;
        mag = ~mag + 64'd1;
      end
    end else begin
      dec = (code == i2a_pkg::BaseDec);
      if (!dec) shift = (code < i2a_pkg::BaseDec) ? int'(code) + 1 : int'(code);
    end
    nd = 0;
    do begin
      if (dec) begin
        digs[nd] = 5'(mag % 64'd10);
        mag      = mag / 64'd10;
      end else begin
        digs[nd] = 5'(mag & ((64'd1 << shift) - 64'd1));
        mag      = mag >> shift;
      end
      nd++;
    end while (mag != 64'd0 && nd < 64);
    pad = int'($signed(item.pad_width));
    if (pad < 0) begin
      pad = dec ? 0 : (64 + shift - 1) / shift;
    end else if (pad > int'(i2a_pkg::MaxChars)) begin
      pad = int'(i2a_pkg::MaxChars);
    end
    fill = pad - int'(neg) - nd;
    if (fill < 0) fill = 0;
    total = int'(neg) + fill + nd;
    for (int k = 0; k < total; k++) begin
      pos = k - int'(neg);
      if (neg && k == 0) begin
        c = i2a_pkg::CharMinus;
      end else if (pos < fill) begin
        c = item.pad_char;
      end else begin
        c = DigitSet[digs[nd - 1 - (pos - fill)]];
      end
      pending_chars.push_back('{char_out: c, last: (k == total - 1), length: 7'(total)});
    end
  endfunction

  function automatic void push_text(input string text);
    for (int k = 0; k < text.len(); k++) begin
      pending_chars.push_back('{char_out: text[k], last: (k == text.len() - 1),
                                length: 7'(text.len())});
    end
  endfunction

  function automatic void add_row(input logic [63:0] value, input logic sgn,
                                  input logic [2:0] code, input int pad,
                                  input logic [7:0] padc, input string text);
    table_items.push_back('{value: value, is_signed: sgn, base_code: code,
                            pad_width: 8'(pad), pad_char: padc});
    table_texts.push_back(text);
  endfunction

  function automatic i2a_pkg::in_t random_item();
    i2a_pkg::in_t item;
    int unsigned  pick;
    int           pw;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: item.value = 64'($urandom_range(0, 999));
      3:       item.value = 64'd1 << $urandom_range(0, 63);
      4:       item.value = ~64'd0 >> $urandom_range(0, 63);
      5, 6:    item.value = -64'($urandom_range(1, 99999));
      default: item.value = {$urandom(), $urandom()};
    endcase
    item.is_signed = ($urandom_range(0, 2) == 0);
    item.base_code = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 19);
    if (pick < 11) begin
      pw = $urandom_range(0, 20);
    end else if (pick < 14) begin
      pw = -1;
    end else if (pick == 14) begin
      pw = -int'($urandom_range(2, 128));
    end else if (pick == 15) begin
      pw = 64;
    end else if (pick == 16) begin
      pw = $urandom_range(65, 127);
    end else begin
      pw = $urandom_range(21, 63);
    end
    item.pad_width = 8'(pw);
    item.pad_char  = 8'($urandom_range(0, 255));
    return item;
  endfunction

  task automatic send_item(input i2a_pkg::in_t item, input string text);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    if (text.len() != 0) push_text(text);
    else format_text(item);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stall per character, one long hold-off
  initial begin
    int unsigned hold;
    out_stall_i <= 1'b0;
    wait (rst_ni);
    forever begin
      if (chars_taken == HoldAfter) hold = HoldCycles;
      else hold = no_gaps ? 0 : $urandom_range(0, 3);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      chars_taken++;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected transfer char_out %h last %b length %0d", $time,
                 out_data_o.char_out, out_data_o.last, out_data_o.length);
        mismatches++;
      end else begin
        if (out_data_o.char_out !== pending_chars[0].char_out) begin
          $display("%0t: char_out expected %h actual %h", $time,
                   pending_chars[0].char_out, out_data_o.char_out);
          mismatches++;
        end
        if (out_data_o.last !== pending_chars[0].last) begin
          $display("%0t: last expected %b actual %b", $time,
                   pending_chars[0].last, out_data_o.last);
          mismatches++;
        end
        if (out_data_o.length !== pending_chars[0].length) begin
          $display("%0t: length expected %0d actual %0d", $time,
                   pending_chars[0].length, out_data_o.length);
          mismatches++;
        end
        void'(pending_chars.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    in_valid_i <= 1'b0;
    in_data_i  <= '0;

    add_row(64'd0, 1'b0, 3'd3, 0, 8'h2A, "0");
    add_row(64'd0, 1'b0, 3'd4, -1, 8'h2E, {"........", ".......", "0"});
    add_row(~64'd0, 1'b0, 3'd4, 0, 8'h2A, {"FFFFFFFF", "FFFFFFFF"});
    add_row(~64'd0, 1'b0, 3'd3, 0, 8'h2A, "18446744073709551615");
    add_row(~64'd0, 1'b0, 3'd2, 0, 8'h2A, {"1", "7777777", "7777777", "7777777"});
    add_row(~64'd0, 1'b0, 3'd5, 0, 8'h2A, {"F", "VVVVVV", "VVVVVV"});
    add_row(~64'd0, 1'b0, 3'd0, -1, 8'h2A, "");
    add_row(~64'd0, 1'b0, 3'd1, 0, 8'h2A, "");
    add_row(64'h8000_0000_0000_0000, 1'b1, 3'd0, 0, 8'h2A, "-9223372036854775808");
    add_row(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 3'd4, 0, 8'h2A, "9223372036854775807");
    add_row(~64'd0, 1'b1, 3'd3, 0, 8'h2A, "-1");
    add_row(-64'd5, 1'b1, 3'd3, 4, 8'h2A, "-**5");
    add_row(64'd42, 1'b1, 3'd3, 5, 8'h20, "   42");
    add_row(-64'd123, 1'b1, 3'd7, 2, 8'h20, "-123");
    add_row(64'd0, 1'b1, 3'd3, 3, 8'h20, "  0");
    add_row(64'd255, 1'b1, 3'd0, 0, 8'h2A, "255");
    add_row(64'd31, 1'b0, 3'd7, 0, 8'h2A, "V");
    add_row(64'd31, 1'b0, 3'd6, 3, 8'h30, "00V");
    add_row(64'd7, 1'b0, 3'd3, -1, 8'h2A, "7");
    add_row(64'd123, 1'b0, 3'd3, 100, 8'h23, "");
    add_row(64'd1, 1'b0, 3'd4, -128, 8'h5F, "");
    add_row(64'd1, 1'b0, 3'd0, 64, 8'h00, "");
    add_row(64'hDEAD_BEEF, 1'b0, 3'd4, 12, 8'hFF, "");
    add_row(64'h1B, 1'b0, 3'd1, 0, 8'h2A, "");
    add_row(~64'd0, 1'b1, 3'd3, 127, 8'h2A, "");

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < table_items.size(); i++) send_item(table_items[i], table_texts[i]);

    for (int i = 0; i < NumRandom; i++) begin
      if (i == 150) drain();
      no_gaps = (i >= 250 && i < 330);
      send_item(random_item(), "");
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
